>>> sv/ptsb_pkg.sv
// Shared types, constants and the arctangent table for the planar scan binner.
// No dependencies; every other file of the block imports this package.
package ptsb_pkg;

  localparam int MAX_BINS = 1024;
  localparam int BIN_W = $clog2(MAX_BINS);
  localparam int CNT_W = $clog2(MAX_BINS + 1);
  localparam int HALF_TURN_BITS = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int ANG_W = HALF_TURN_BITS + 2;
  localparam int CXY_W = 19;
  localparam int MUL_A_W = HALF_TURN_BITS;
  localparam int MUL_B_W = 17;
  localparam int PROD_W = MUL_A_W + MUL_B_W;

  typedef enum logic [1:0] {
    ACT_POINT = 2'd0,
    ACT_READ  = 2'd1,
    ACT_START = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CFG_GROUND_SLOPE  = 3'd0,
    CFG_GROUND_HEIGHT = 3'd1,
    CFG_CAMERA_SLOPE  = 3'd2,
    CFG_CAMERA_HEIGHT = 3'd3,
    CFG_MIN_RANGE     = 3'd4,
    CFG_NUM_BINS      = 3'd5,
    CFG_POINT_SKIP    = 3'd6,
    CFG_UNUSED        = 3'd7
  } cfg_idx_e;

  // Control from the sequencer to the iterative units.
  typedef struct packed {
    logic              load;
    logic              step;
    logic [STEP_W-1:0] idx;
  } iter_ctrl_t;

  // atan(2^-i) in units of a half turn / 2^20.
  function automatic logic [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      4'd0:    v = 22'd262144;
      4'd1:    v = 22'd154753;
      4'd2:    v = 22'd81767;
      4'd3:    v = 22'd41506;
      4'd4:    v = 22'd20834;
      4'd5:    v = 22'd10427;
      4'd6:    v = 22'd5215;
      4'd7:    v = 22'd2608;
      4'd8:    v = 22'd1304;
      4'd9:    v = 22'd652;
      4'd10:   v = 22'd326;
      4'd11:   v = 22'd163;
      4'd12:   v = 22'd81;
      4'd13:   v = 22'd41;
      4'd14:   v = 22'd20;
      default: v = 22'd10;
    endcase
    return v;
  endfunction

endpackage

>>> sv/ptsb_cordic.sv
// Iterative CORDIC in vectoring mode: one micro-rotation per step.
// Depends on ptsb_pkg for the step control struct and the arctangent table.
module ptsb_cordic import ptsb_pkg::*; (
  input  logic                    clk_i,
  input  iter_ctrl_t              ctrl_i,
  input  logic signed [15:0]      x_i,
  input  logic signed [15:0]      y_i,
  output logic signed [ANG_W-1:0] z_o
);

  logic signed [CXY_W-1:0] cx_q, cx_d, cy_q, cy_d, dx, dy;
  logic signed [ANG_W-1:0] z_q, z_d;

  // Shift-add rotation towards the x axis; the shifts round towards minus infinity.
  always_comb begin
    dx = cy_q >>> ctrl_i.idx;
    dy = cx_q >>> ctrl_i.idx;
    cx_d = cx_q;
    cy_d = cy_q;
    z_d = z_q;
    if (ctrl_i.load) begin
      cx_d = CXY_W'(x_i);
      cy_d = CXY_W'(y_i);
      z_d = '0;
    end else if (ctrl_i.step) begin
      if (!cy_q[CXY_W-1]) begin
        cx_d = cx_q + dx;
        cy_d = cy_q - dy;
        z_d = z_q + $signed(atan_entry(ctrl_i.idx));
      end else begin
        cx_d = cx_q - dx;
        cy_d = cy_q + dy;
        z_d = z_q - $signed(atan_entry(ctrl_i.idx));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d;
    cy_q <= cy_d;
    z_q <= z_d;
  end

  assign z_o = z_q;

endmodule

>>> sv/ptsb_isqrt.sv
// Bit-pair integer square root: one result bit per step over sixteen steps.
// Depends on ptsb_pkg for the step control struct.
module ptsb_isqrt import ptsb_pkg::*; (
  input  logic        clk_i,
  input  iter_ctrl_t  ctrl_i,
  input  logic [31:0] v_i,
  output logic [15:0] root_o
);

  logic [31:0] v_q, v_d, res_q, res_d, bitv, trial;

  // Trial subtraction of the current bit pair.
  always_comb begin
    bitv = 32'h4000_0000 >> {ctrl_i.idx, 1'b0};
    trial = res_q + bitv;
    v_d = v_q;
    res_d = res_q;
    if (ctrl_i.load) begin
      v_d = v_i;
      res_d = '0;
    end else if (ctrl_i.step) begin
      if (v_q >= trial) begin
        v_d = v_q - trial;
        res_d = (res_q >> 1) + bitv;
      end else begin
        res_d = res_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    res_q <= res_d;
  end

  assign root_o = res_q[15:0];

endmodule

>>> sv/point_to_scan_min_range_binning_top.sv
// Top level of the planar scan binner: sequencer, shared multiplier and bin memory.
// Depends on ptsb_pkg, ptsb_cordic and ptsb_isqrt.
//
// Usage. Input words arrive on in_valid_i/in_ready_o with the action and point
// fields; each word gives exactly one result word on out_valid_o/out_ready_i.
// Configuration writes on cfg_valid_i/cfg_ready_o (register index, data) are always
// accepted; the user must make them only while the block is idle (not enforced).
// Flow. A point word goes from acceptance to its result register through the
// slope tests and squares on the shared 20x17 multiplier, sixteen iterations of
// the CORDIC and square-root units, one multiply for the bin and a
// read-modify-write of the bin memory; a rejected or too-near point ends early.
// A skipped or invalid point goes straight to its result, a read word through
// a memory read. A start word clears the bin memory one entry a cycle.
// Reset. After reset the block runs a clearing pass over the whole bin memory
// with in_ready_o low; configuration writes are taken meanwhile.
// Stalls. One word is processed at a time; the finished result sits in an
// output register, so the next word is accepted while the receiver stalls, and
// it waits at its last step until that register is free.
module point_to_scan_min_range_binning_top import ptsb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic signed [15:0] point_x_mm_i,
  input  logic signed [15:0] point_y_mm_i,
  input  logic signed [15:0] point_z_mm_i,
  input  logic              point_valid_i,
  input  logic [9:0]        bin_select_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              point_used_o,
  output logic [9:0]        bin_index_o,
  output logic [15:0]       range_mm_o,
  output logic              no_return_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_CLEAR = 12'b0000_0000_0010,
    ST_GND   = 12'b0000_0000_0100,
    ST_CAM   = 12'b0000_0000_1000,
    ST_SQX   = 12'b0000_0001_0000,
    ST_SQY   = 12'b0000_0010_0000,
    ST_ADD   = 12'b0000_0100_0000,
    ST_ITER  = 12'b0000_1000_0000,
    ST_BIN   = 12'b0001_0000_0000,
    ST_LOOK  = 12'b0010_0000_0000,
    ST_UPD   = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] ground_slope_q, camera_slope_q, min_range_q;
  logic [14:0] ground_height_q;
  logic signed [15:0] camera_height_q;
  logic [10:0] num_bins_q;
  logic [7:0]  point_skip_q, stride_q;

  // Item and working registers.
  action_e act_q;
  logic signed [15:0] x_q, y_q, z_q;
  logic [BIN_W-1:0] bin_q;
  logic [CNT_W-1:0] clr_q;
  logic [STEP_W-1:0] idx_q;
  logic gnd_rej_q, clr_item_q;
  logic [31:0] sumsq_q;
  logic [PROD_W-1:0] prod_q;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  // Result under construction and the output register.
  logic res_used_q, res_nr_q;
  logic [9:0] res_bin_q;
  logic [15:0] res_range_q;
  logic out_valid_q, out_used_q, out_nr_q;
  logic [9:0] out_bin_q;
  logic [15:0] out_range_q;

  logic in_acc, out_free, considered;
  logic [16:0] ax, ay, az, dz;
  logic reject;
  logic signed [ANG_W-1:0] ang, ang_sh;
  logic [MUL_A_W-1:0] phi;
  logic [10:0] n_clamp;
  logic [15:0] root;
  iter_ctrl_t iter_ctrl;

  // Bin memory: {hit, range}, one read and one write port, registered read.
  logic [16:0] mem_q [MAX_BINS];
  logic [16:0] rdata_q;
  logic mem_we;
  logic [BIN_W-1:0] mem_waddr, mem_raddr;
  logic [16:0] mem_wdata;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign considered = (stride_q == '0);

  // Magnitudes used by the slope tests and squares.
  always_comb begin
    ax = x_q[15] ? 17'(-{x_q[15], x_q}) : 17'({1'b0, x_q});
    ay = y_q[15] ? 17'(-{y_q[15], y_q}) : 17'({1'b0, y_q});
    az = z_q[15] ? 17'(-{z_q[15], z_q}) : 17'({1'b0, z_q});
    dz = 17'($signed({z_q[15], z_q}) - $signed({camera_height_q[15], camera_height_q}));
    if (dz[16]) begin
      dz = 17'(-dz);
    end
  end

  // Half-circle phase (minus y at zero, plus x mid-range) and clamped bin count.
  always_comb begin
    ang_sh = ang + ANG_W'(1 << (HALF_TURN_BITS - 1));
    if (x_q == '0) begin
      phi = '0;
    end else if (ang_sh[ANG_W-1]) begin
      phi = '0;
    end else if (ang_sh > ANG_W'((1 << HALF_TURN_BITS) - 1)) begin
      phi = '1;
    end else begin
      phi = ang_sh[MUL_A_W-1:0];
    end
    if (num_bins_q == '0) begin
      n_clamp = 11'd1;
    end else if (num_bins_q > 11'(MAX_BINS)) begin
      n_clamp = 11'(MAX_BINS);
    end else begin
      n_clamp = num_bins_q;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_GND: begin
        mul_a = MUL_A_W'(ground_slope_q);
        mul_b = ax;
      end
      ST_CAM: begin
        mul_a = MUL_A_W'(camera_slope_q);
        mul_b = ax;
      end
      ST_SQX: begin
        mul_a = MUL_A_W'(ax);
        mul_b = ax;
      end
      ST_SQY: begin
        mul_a = MUL_A_W'(ay);
        mul_b = ay;
      end
      ST_BIN: begin
        mul_a = phi;
        mul_b = MUL_B_W'(n_clamp);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Camera-cone test on the product issued in the previous cycle, plus the
  // ground-slope result, the ground height and behind-the-sensor cases.
  assign reject = gnd_rej_q ||
                  (({dz, 12'b0} > 29'(prod_q)) && (prod_q[PROD_W-1:29] == '0)) ||
                  (az < 17'(ground_height_q)) || x_q[15] ||
                  ((x_q == '0) && !y_q[15]);

  assign iter_ctrl.load = (state_q == ST_ADD);
  assign iter_ctrl.step = (state_q == ST_ITER);
  assign iter_ctrl.idx = idx_q;

  ptsb_cordic u_cordic (
    .clk_i  (clk_i),
    .ctrl_i (iter_ctrl),
    .x_i    (x_q),
    .y_i    (y_q),
    .z_o    (ang)
  );

  ptsb_isqrt u_isqrt (
    .clk_i  (clk_i),
    .ctrl_i (iter_ctrl),
    .v_i    (sumsq_q + prod_q[31:0]),
    .root_o (root)
  );

  // Memory port control.
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = bin_q;
    mem_wdata = {1'b1, root};
    mem_raddr = (act_q == ACT_POINT) ? prod_q[HALF_TURN_BITS +: BIN_W] : bin_q;
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_waddr = clr_q[BIN_W-1:0];
      mem_wdata = '0;
    end else if (state_q == ST_UPD && act_q == ACT_POINT) begin
      mem_we = !rdata_q[16] || (root < rdata_q[15:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (action_e'(action_i))
            ACT_POINT: state_d = (considered && point_valid_i) ? ST_GND : ST_DONE;
            ACT_READ:  state_d = ST_LOOK;
            ACT_START: state_d = ST_CLEAR;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_q == CNT_W'(MAX_BINS - 1)) begin
          state_d = clr_item_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_GND:  state_d = ST_CAM;
      ST_CAM:  state_d = ST_SQX;
      ST_SQX:  state_d = reject ? ST_DONE : ST_SQY;
      ST_SQY:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_ITER;
      ST_ITER: state_d = (idx_q == '1) ? ST_BIN : ST_ITER;
      ST_BIN:  state_d = (root > min_range_q) ? ST_LOOK : ST_DONE;
      ST_LOOK: state_d = ST_UPD;
      ST_UPD:  state_d = ST_DONE;
      ST_DONE: state_d = out_free ? ST_IDLE : ST_DONE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      clr_item_q <= 1'b0;
      idx_q <= '0;
      stride_q <= '0;
      act_q <= ACT_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == ST_ITER) begin
        idx_q <= idx_q + 1'b1;
      end
      if (in_acc) begin
        act_q <= action_e'(action_i);
        clr_item_q <= 1'b1;
        clr_q <= '0;
        idx_q <= '0;
        unique case (action_e'(action_i))
          ACT_POINT: stride_q <= considered ? point_skip_q : stride_q - 1'b1;
          ACT_START: stride_q <= '0;
          default:   stride_q <= stride_q;
        endcase
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ground_slope_q <= 16'd410;
      ground_height_q <= 15'd50;
      camera_slope_q <= 16'd4096;
      camera_height_q <= '0;
      min_range_q <= 16'd100;
      num_bins_q <= 11'd256;
      point_skip_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GROUND_SLOPE:  ground_slope_q <= cfg_data_i;
        CFG_GROUND_HEIGHT: ground_height_q <= cfg_data_i[14:0];
        CFG_CAMERA_SLOPE:  camera_slope_q <= cfg_data_i;
        CFG_CAMERA_HEIGHT: camera_height_q <= cfg_data_i;
        CFG_MIN_RANGE:     min_range_q <= cfg_data_i;
        CFG_NUM_BINS:      num_bins_q <= cfg_data_i[10:0];
        CFG_POINT_SKIP:    point_skip_q <= cfg_data_i[7:0];
        default:           ;
      endcase
    end
  end

  // Payload registers of the item, the working values and the result.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= point_x_mm_i;
      y_q <= point_y_mm_i;
      z_q <= point_z_mm_i;
      bin_q <= bin_select_i;
      res_used_q <= 1'b0;
      res_bin_q <= '0;
      res_range_q <= '0;
      res_nr_q <= 1'b0;
    end
    if (state_q == ST_CAM) begin
      gnd_rej_q <= ({az, 12'b0} < 29'(prod_q)) || (prod_q[PROD_W-1:29] != '0);
    end
    if (state_q == ST_SQY) begin
      sumsq_q <= prod_q[31:0];
    end
    if (state_q == ST_LOOK && act_q == ACT_POINT) begin
      bin_q <= prod_q[HALF_TURN_BITS +: BIN_W];
    end
    if (state_q == ST_UPD) begin
      res_bin_q <= bin_q;
      if (act_q == ACT_POINT) begin
        res_range_q <= root;
        res_used_q <= !rdata_q[16] || (root < rdata_q[15:0]);
      end else if (rdata_q[16]) begin
        res_range_q <= rdata_q[15:0];
      end else begin
        res_range_q <= '1;
        res_nr_q <= 1'b1;
      end
    end
    if (state_q == ST_DONE && out_free) begin
      out_used_q <= res_used_q;
      out_bin_q <= res_bin_q;
      out_range_q <= res_range_q;
      out_nr_q <= res_nr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_used_o = out_used_q;
  assign bin_index_o = out_bin_q;
  assign range_mm_o = out_range_q;
  assign no_return_o = out_nr_q;

  // A word is worked on alone: no second word straight after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input accepted while a word is in progress");

  // A no-return result always carries the all-ones range code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && no_return_o) |-> (range_mm_o == 16'hFFFF))
    else $error("no-return result without the empty range code");

  // A point that updated its bin is never reported as a no-return read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && point_used_o) |-> !no_return_o)
    else $error("used point flagged as no-return");

endmodule
